/* rtl/revision_ack_window_tracker_defines.svh */
// Assertion macros for the revision acknowledge window tracker.
`ifndef REVISION_ACK_WINDOW_TRACKER_DEFINES_SVH
`define REVISION_ACK_WINDOW_TRACKER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RAWT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RAWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rawt_pkg.sv */
// Shared types and constants for the revision acknowledge window tracker.
package rawt_pkg;

  localparam int REV_W      = 64;
  localparam int WINDOW     = 64;  // power of two
  localparam int SW         = $clog2(WINDOW);
  localparam int GW         = $clog2(WINDOW + 1);
  localparam int PEND_W     = 7;
  localparam int PW         = (GW > PEND_W) ? GW : PEND_W;
  localparam int FUNC_W     = 2;
  localparam int STAGE_W    = 3;
  localparam int STATUS_W   = 4;
  localparam int IN_DATA_W  = 264;
  localparam int OUT_DATA_W = 208;
  localparam int CFG_ADDR_W = 4;

  localparam logic [STAGE_W-1:0] STAGE_MAX = 3'd3;

  typedef enum logic [FUNC_W-1:0] {
    FN_RECORD,
    FN_ACK_ONE,
    FN_ACK_THRU,
    FN_NONE
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_ALREADY,
    ST_ZERO,
    ST_FUTURE,
    ST_EXHAUSTED,
    ST_WIN_FULL,
    ST_BAD_STAGE,
    ST_DL_EARLY,
    ST_NE_EARLY
  } status_t;

  typedef enum logic {
    ALU_SUB,
    ALU_INC
  } alu_op_t;

  typedef struct packed {
    logic [REV_W-1:0] a;
    logic [REV_W-1:0] b;
    alu_op_t          op;
  } alu_req_t;

  typedef struct packed {
    logic [REV_W-1:0] res;
    logic             borrow;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DL,
    S_NE,
    S_WIN,
    S_INC,
    S_A1_HI,
    S_A1_LO,
    S_AT_HI,
    S_AT_LO,
    S_AT_WALK,
    S_ADV,
    S_DONE
  } state_t;

endpackage

/* rtl/revision_ack_window_tracker.sv */
// Top level of the revision acknowledge window tracker.
//
// One request at a time runs through a sequencer that drives a single shared
// 64-bit subtract/increment unit. A record passes through idle, four
// check/update steps and one step to load the result register. An acknowledge
// checks the revision, sets its mark and advances the acknowledged pointer one
// revision per step, with a closing step. An acknowledge-through checks the
// revision, walks the pointer one step per revision covered, then advances it
// one step per marked revision passed afterwards, with a closing step. Covered
// and passed revisions together never exceed the outstanding count. A failed
// check ends the item early. Each pointer step is one pass through the shared
// unit. in_tready is high only while the sequencer is idle; a finished result
// waits in the output register while the next request is taken, and a result
// that is not taken holds the sequencer in its last step.
`include "revision_ack_window_tracker_defines.svh"
module revision_ack_window_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: ack_revision, work_stage, earliest_time, deadline_time,
  //        deadline_present, next_eval_time, next_eval_present
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rawt_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: func
  input  logic [rawt_pkg::FUNC_W-1:0]         in_tuser,
  // tdata: status, issued_revision, current_revision, acked_revision,
  //        pending_count
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rawt_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rawt_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [rawt_pkg::REV_W-1:0]          cfg_pwdata,
  output logic [rawt_pkg::REV_W-1:0]          cfg_prdata,
  output logic                                cfg_pready
);
  import rawt_pkg::*;

  state_t state_r, state_nxt;

  logic [REV_W-1:0]   restored_r, restored_nxt;
  logic [REV_W-1:0]   issued_r, issued_nxt;
  logic [REV_W-1:0]   ackp_r, ackp_nxt;
  logic [WINDOW-1:0]  bitmap_r, bitmap_nxt;
  logic [GW-1:0]      gap_r, gap_nxt;
  logic [GW-1:0]      marked_r, marked_nxt;
  logic [GW-1:0]      cnt_r, cnt_nxt;

  func_t              func_r, func_nxt;
  logic [REV_W-1:0]   rev_r, rev_nxt;
  logic [STAGE_W-1:0] stage_r, stage_nxt;
  logic [REV_W-1:0]   earliest_r, earliest_nxt;
  logic [REV_W-1:0]   deadline_r, deadline_nxt;
  logic               dl_p_r, dl_p_nxt;
  logic [REV_W-1:0]   next_eval_r, next_eval_nxt;
  logic               ne_p_r, ne_p_nxt;
  status_t            status_r, status_nxt;
  logic [REV_W-1:0]   iss_out_r, iss_out_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic          in_acc;
  logic          cfg_wr;
  logic          out_free;
  logic          dl_fail, ne_fail, win_fail, hi_fail, a1_lo_fail, at_lo_fail;
  logic          adv_step;
  logic [SW-1:0] rev_slot, adv_slot, alu_slot;
  logic [PW-1:0] pend;

  rawt_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[3];
  assign cfg_prdata = cfg_paddr[3] ? '0 : restored_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign rev_slot = rev_r[SW-1:0];
  assign adv_slot = SW'(ackp_r[SW-1:0] + SW'(1));
  assign alu_slot = alu_rsp.res[SW-1:0];
  assign pend     = PW'(gap_r) - PW'(marked_r);

  assign dl_fail    = (stage_r > STAGE_MAX) || (dl_p_r && alu_rsp.borrow);
  assign ne_fail    = ne_p_r && alu_rsp.borrow;
  assign win_fail   = (&issued_r) || (gap_r >= GW'(WINDOW));
  assign hi_fail    = ((func_r == FN_ACK_ONE) && (rev_r == '0)) || alu_rsp.borrow;
  assign a1_lo_fail = !alu_rsp.borrow || bitmap_r[rev_slot];
  assign at_lo_fail = alu_rsp.borrow || (alu_rsp.res == '0);
  assign adv_step   = (gap_r != '0) && bitmap_r[adv_slot];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (func_t'(in_tuser))
            FN_RECORD:   state_nxt = S_DL;
            FN_ACK_ONE:  state_nxt = S_A1_HI;
            FN_ACK_THRU: state_nxt = S_AT_HI;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_DL:      state_nxt = dl_fail ? S_DONE : S_NE;
      S_NE:      state_nxt = ne_fail ? S_DONE : S_WIN;
      S_WIN:     state_nxt = win_fail ? S_DONE : S_INC;
      S_INC:     state_nxt = S_DONE;
      S_A1_HI:   state_nxt = hi_fail ? S_DONE : S_A1_LO;
      S_A1_LO:   state_nxt = a1_lo_fail ? S_DONE : S_ADV;
      S_AT_HI:   state_nxt = hi_fail ? S_DONE : S_AT_LO;
      S_AT_LO:   state_nxt = at_lo_fail ? S_DONE : S_AT_WALK;
      S_AT_WALK: state_nxt = (cnt_r == GW'(1)) ? S_ADV : S_AT_WALK;
      S_ADV:     state_nxt = adv_step ? S_ADV : S_DONE;
      S_DONE:    state_nxt = out_free ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // shared unit operands
  always_comb begin
    alu_req.a  = ackp_r;
    alu_req.b  = rev_r;
    alu_req.op = ALU_SUB;
    case (state_r)
      S_DL: begin
        alu_req.a = deadline_r;
        alu_req.b = earliest_r;
      end
      S_NE: begin
        alu_req.a = next_eval_r;
        alu_req.b = earliest_r;
      end
      S_INC: begin
        alu_req.a  = issued_r;
        alu_req.op = ALU_INC;
      end
      S_A1_HI, S_AT_HI: begin
        alu_req.a = issued_r;
        alu_req.b = rev_r;
      end
      S_AT_LO: begin
        alu_req.a = rev_r;
        alu_req.b = ackp_r;
      end
      S_AT_WALK, S_ADV: begin
        alu_req.a  = ackp_r;
        alu_req.op = ALU_INC;
      end
      default: begin
        alu_req.a  = ackp_r;
        alu_req.b  = rev_r;
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  // datapath
  always_comb begin
    restored_nxt  = restored_r;
    issued_nxt    = issued_r;
    ackp_nxt      = ackp_r;
    bitmap_nxt    = bitmap_r;
    gap_nxt       = gap_r;
    marked_nxt    = marked_r;
    cnt_nxt       = cnt_r;
    func_nxt      = func_r;
    rev_nxt       = rev_r;
    stage_nxt     = stage_r;
    earliest_nxt  = earliest_r;
    deadline_nxt  = deadline_r;
    dl_p_nxt      = dl_p_r;
    next_eval_nxt = next_eval_r;
    ne_p_nxt      = ne_p_r;
    status_nxt    = status_r;
    iss_out_nxt   = iss_out_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_wr) begin
      restored_nxt = cfg_pwdata;
      issued_nxt   = cfg_pwdata;
      ackp_nxt     = cfg_pwdata;
      bitmap_nxt   = '0;
      gap_nxt      = '0;
      marked_nxt   = '0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt      = func_t'(in_tuser);
          rev_nxt       = in_tdata[63:0];
          stage_nxt     = in_tdata[66:64];
          earliest_nxt  = in_tdata[130:67];
          deadline_nxt  = in_tdata[194:131];
          dl_p_nxt      = in_tdata[195];
          next_eval_nxt = in_tdata[259:196];
          ne_p_nxt      = in_tdata[260];
          status_nxt    = ST_OK;
          iss_out_nxt   = '0;
        end
      end
      S_DL: begin
        if (stage_r > STAGE_MAX) begin
          status_nxt = ST_BAD_STAGE;
        end else if (dl_fail) begin
          status_nxt = ST_DL_EARLY;
        end
      end
      S_NE: begin
        if (ne_fail) begin
          status_nxt = ST_NE_EARLY;
        end
      end
      S_WIN: begin
        if (&issued_r) begin
          status_nxt = ST_EXHAUSTED;
        end else if (win_fail) begin
          status_nxt = ST_WIN_FULL;
        end
      end
      S_INC: begin
        issued_nxt  = alu_rsp.res;
        iss_out_nxt = alu_rsp.res;
        gap_nxt     = GW'(gap_r + GW'(1));
        if (bitmap_r[alu_slot]) begin
          bitmap_nxt[alu_slot] = 1'b0;
          marked_nxt           = GW'(marked_r - GW'(1));
        end
      end
      S_A1_HI, S_AT_HI: begin
        if ((func_r == FN_ACK_ONE) && (rev_r == '0)) begin
          status_nxt = ST_ZERO;
        end else if (alu_rsp.borrow) begin
          status_nxt = ST_FUTURE;
        end
      end
      S_A1_LO: begin
        if (a1_lo_fail) begin
          status_nxt = ST_ALREADY;
        end else begin
          bitmap_nxt[rev_slot] = 1'b1;
          marked_nxt           = GW'(marked_r + GW'(1));
        end
      end
      S_AT_LO: begin
        if (at_lo_fail) begin
          status_nxt = ST_ALREADY;
        end else begin
          cnt_nxt = alu_rsp.res[GW-1:0];
        end
      end
      S_AT_WALK: begin
        ackp_nxt = alu_rsp.res;
        gap_nxt  = GW'(gap_r - GW'(1));
        cnt_nxt  = GW'(cnt_r - GW'(1));
        if (bitmap_r[alu_slot]) begin
          bitmap_nxt[alu_slot] = 1'b0;
          marked_nxt           = GW'(marked_r - GW'(1));
        end
      end
      S_ADV: begin
        if (adv_step) begin
          ackp_nxt             = alu_rsp.res;
          gap_nxt              = GW'(gap_r - GW'(1));
          bitmap_nxt[adv_slot] = 1'b0;
          marked_nxt           = GW'(marked_r - GW'(1));
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_DATA_W - 203){1'b0}}, pend[PEND_W-1:0], ackp_r,
                           issued_r, iss_out_r, status_r};
        end
      end
      default: begin
        status_nxt = status_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      restored_r  <= '0;
      issued_r    <= '0;
      ackp_r      <= '0;
      bitmap_r    <= '0;
      gap_r       <= '0;
      marked_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      restored_r  <= restored_nxt;
      issued_r    <= issued_nxt;
      ackp_r      <= ackp_nxt;
      bitmap_r    <= bitmap_nxt;
      gap_r       <= gap_nxt;
      marked_r    <= marked_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    func_r      <= func_nxt;
    rev_r       <= rev_nxt;
    stage_r     <= stage_nxt;
    earliest_r  <= earliest_nxt;
    deadline_r  <= deadline_nxt;
    dl_p_r      <= dl_p_nxt;
    next_eval_r <= next_eval_nxt;
    ne_p_r      <= ne_p_nxt;
    status_r    <= status_nxt;
    iss_out_r   <= iss_out_nxt;
    out_data_r  <= out_data_nxt;
  end

  `RAWT_ASSERT_NOW(a_gap_bound, 1'b1, gap_r <= GW'(WINDOW), "outstanding count above window")
  `RAWT_ASSERT_NOW(a_marked_le_gap, 1'b1, marked_r <= gap_r, "more marks than outstanding")
  `RAWT_ASSERT_NOW(a_marked_count, 1'b1, $countones(bitmap_r) == int'(marked_r),
                   "mark count out of step with bitmap")
  `RAWT_ASSERT_NEXT(a_busy_after_req, in_acc, state_r != S_IDLE,
                    "sequencer idle after taking a request")

endmodule

/* rtl/rawt_alu.sv */
// Shared 64-bit subtract / increment unit.
module rawt_alu (
  input  rawt_pkg::alu_req_t req,
  output rawt_pkg::alu_rsp_t rsp
);
  import rawt_pkg::*;

  logic [REV_W-1:0] b_eff;
  logic [REV_W:0]   sum;

  // a - b as a + ~b + 1; increment as a + 0 + 1
  assign b_eff = (req.op == ALU_SUB) ? ~req.b : '0;
  assign sum   = {1'b0, req.a} + {1'b0, b_eff} + {{REV_W{1'b0}}, 1'b1};

  assign rsp.res    = sum[REV_W-1:0];
  assign rsp.borrow = (req.op == ALU_SUB) && !sum[REV_W];

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the revision acknowledge window tracker.
module tb_top;
  import rawt_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 2 * WINDOW + 40;
  localparam logic [CFG_ADDR_W-1:0] RESTORED_REV_ADDR = '0;
  localparam logic [REV_W-1:0] REV_MAX = '1;

  typedef struct packed {
    func_t              func;
    logic [REV_W-1:0]   rev;
    logic [STAGE_W-1:0] stage;
    logic [REV_W-1:0]   earliest;
    logic [REV_W-1:0]   deadline;
    logic               dl_present;
    logic [REV_W-1:0]   next_eval;
    logic               ne_present;
  } change_req_t;

  typedef struct packed {
    status_t           status;
    logic [REV_W-1:0]  issued;
    logic [REV_W-1:0]  current;
    logic [REV_W-1:0]  acked;
    logic [PEND_W-1:0] pending;
  } rev_report_t;

  typedef struct packed {
    logic [REV_W-1:0]  issued;
    logic [REV_W-1:0]  acked;
    logic [WINDOW-1:0] marks;
  } tracker_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [FUNC_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [REV_W-1:0] cfg_pwdata = '0;
  logic [REV_W-1:0] cfg_prdata;
  logic cfg_pready;

  revision_ack_window_tracker dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  change_req_t    change_q[$];
  rev_report_t    awaited_reports[$];
  change_req_t    cur_req = '0;
  tracker_state_t model_tracker = '0;
  tracker_state_t stim_tracker = '0;
  int             mismatches = 0;
  int             burst_left = 0;
  int             gap_left = 0;
  int             hold_left = 0;
  int             rx_cycles = 0;
  int             rx_mode = 0;
  int             cycle_count = 0;

  function automatic logic [REV_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int slot_of(logic [REV_W-1:0] rev);
    return int'(rev % WINDOW);
  endfunction

  function automatic void advance_acked(inout tracker_state_t st);
    while (st.acked < st.issued) begin
      if (!st.marks[slot_of(st.acked + 1)]) break;
      st.marks[slot_of(st.acked + 1)] = 1'b0;
      st.acked++;
    end
  endfunction

  function automatic rev_report_t track_change(inout tracker_state_t st, input change_req_t c);
    rev_report_t rep;
    rep = '0;
    rep.status = ST_OK;
    case (c.func)
      FN_RECORD: begin
        if (c.stage > STAGE_MAX) rep.status = ST_BAD_STAGE;
        else if (c.dl_present && c.deadline < c.earliest) rep.status = ST_DL_EARLY;
        else if (c.ne_present && c.next_eval < c.earliest) rep.status = ST_NE_EARLY;
        else if (st.issued == REV_MAX) rep.status = ST_EXHAUSTED;
        else if (st.issued - st.acked >= WINDOW) rep.status = ST_WIN_FULL;
        else begin
          st.issued++;
          st.marks[slot_of(st.issued)] = 1'b0;
          rep.issued = st.issued;
        end
      end
      FN_ACK_ONE: begin
        if (c.rev == 0) rep.status = ST_ZERO;
        else if (c.rev > st.issued) rep.status = ST_FUTURE;
        else if (c.rev <= st.acked || st.marks[slot_of(c.rev)]) rep.status = ST_ALREADY;
        else begin
          st.marks[slot_of(c.rev)] = 1'b1;
          advance_acked(st);
        end
      end
      FN_ACK_THRU: begin
        if (c.rev > st.issued) rep.status = ST_FUTURE;
        else if (c.rev <= st.acked) rep.status = ST_ALREADY;
        else begin
          while (st.acked < c.rev) begin
            st.acked++;
            st.marks[slot_of(st.acked)] = 1'b0;
          end
          advance_acked(st);
        end
      end
      default: ;
    endcase
    rep.current = st.issued;
    rep.acked = st.acked;
    rep.pending = PEND_W'(st.issued - st.acked - REV_W'($countones(st.marks)));
    return rep;
  endfunction

  // Mostly well-formed traffic against the current window; a slice is malformed.
  function automatic change_req_t random_change(tracker_state_t st, int rec_pct);
    change_req_t c;
    logic [REV_W-1:0] a;
    logic [REV_W-1:0] b;
    logic [REV_W-1:0] outstanding;
    int pick;
    c.func = FN_RECORD;
    c.rev = rand64();
    c.stage = STAGE_W'($urandom_range(0, 3));
    a = rand64();
    b = rand64();
    c.earliest = (a < b) ? a : b;
    c.deadline = (a < b) ? b : a;
    c.dl_present = 1'($urandom_range(0, 1));
    b = rand64();
    c.next_eval = (b >= c.earliest) ? b : c.earliest;
    c.ne_present = 1'($urandom_range(0, 1));
    outstanding = st.issued - st.acked;
    pick = (outstanding == 0 && $urandom_range(0, 7) != 0) ? 0 : $urandom_range(0, 99);
    if (pick < rec_pct) begin
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 2))
          0: c.stage = STAGE_W'($urandom_range(4, 7));
          1: begin
            c.dl_present = 1'b1;
            c.deadline = c.earliest - 1 - $urandom_range(0, 3);
          end
          default: begin
            c.ne_present = 1'b1;
            c.next_eval = c.earliest - 1 - $urandom_range(0, 3);
          end
        endcase
      end
    end else if (pick < 98) begin
      c.func = (pick < rec_pct + (100 - rec_pct) * 2 / 3) ? FN_ACK_ONE : FN_ACK_THRU;
      if (outstanding != 0 && $urandom_range(0, 9) != 0) begin
        if (c.func == FN_ACK_THRU && outstanding > 8 && $urandom_range(0, 1) == 0)
          c.rev = st.acked + 1 + ($urandom % 8);
        else
          c.rev = st.acked + 1 + ($urandom % outstanding);
      end else begin
        case ($urandom_range(0, 3))
          0: c.rev = '0;
          1: c.rev = st.issued + 1 + $urandom_range(0, 3);
          2: c.rev = st.acked - $urandom_range(0, 3);
          default: c.rev = rand64();
        endcase
      end
    end else begin
      c.func = FN_NONE;
    end
    return c;
  endfunction

  task automatic add_directed(func_t f, logic [REV_W-1:0] rev, logic [STAGE_W-1:0] stage,
                              logic [REV_W-1:0] earliest, logic [REV_W-1:0] deadline,
                              logic dl_present, logic [REV_W-1:0] next_eval,
                              logic ne_present);
    change_req_t c;
    c = '{f, rev, stage, earliest, deadline, dl_present, next_eval, ne_present};
    void'(track_change(stim_tracker, c));
    change_q.insert(change_q.size(), c);
  endtask

  task automatic add_random(int count, int rec_pct);
    change_req_t c;
    repeat (count) begin
      c = random_change(stim_tracker, rec_pct);
      void'(track_change(stim_tracker, c));
      change_q.insert(change_q.size(), c);
    end
  endtask

  task automatic wait_drained();
    while (change_q.size() != 0 || in_tvalid || awaited_reports.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_restored(logic [REV_W-1:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= RESTORED_REV_ADDR;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    model_tracker = '{v, v, '0};
    stim_tracker = model_tracker;
    @(negedge clk);
  endtask

  task automatic run_phase(logic [REV_W-1:0] start_rev, int count, int rec_pct);
    wait_drained();
    write_restored(start_rev);
    add_random(count / 2, rec_pct);
    wait_drained();
    add_random(count - count / 2, rec_pct);
  endtask

  task automatic compare_field(string name, logic [REV_W-1:0] want, logic [REV_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    change_req_t nx;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        awaited_reports.insert(awaited_reports.size(), track_change(model_tracker, cur_req));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (change_q.size() != 0) begin
          nx = change_q.pop_front();
          cur_req <= nx;
          in_tdata <= {3'b000, nx.ne_present, nx.next_eval, nx.dl_present, nx.deadline,
                       nx.earliest, nx.stage, nx.rev};
          in_tuser <= nx.func;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver: changing stall mode plus a periodic long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (rx_cycles % 256 == 0) rx_mode <= $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (rx_cycles % 8192 == 3000) begin
        hold_left <= 600;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    rev_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected result: tdata 0x%0h", out_tdata);
        mismatches++;
      end else begin
        want = awaited_reports.pop_front();
        compare_field("status", REV_W'(want.status), REV_W'(out_tdata[3:0]));
        compare_field("issued_revision", want.issued, out_tdata[67:4]);
        compare_field("current_revision", want.current, out_tdata[131:68]);
        compare_field("acked_revision", want.acked, out_tdata[195:132]);
        compare_field("pending_count", REV_W'(want.pending), REV_W'(out_tdata[202:196]));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_restored('0);
    add_directed(FN_RECORD, '0, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_RECORD, REV_MAX, 3'd3, REV_MAX, REV_MAX, 1'b1, REV_MAX, 1'b1);
    add_directed(FN_RECORD, '0, 3'd4, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_RECORD, '0, 3'd7, 64'd9, 64'd1, 1'b1, '0, 1'b0);
    add_directed(FN_RECORD, '0, 3'd1, REV_MAX, '0, 1'b1, '0, 1'b1);
    add_directed(FN_RECORD, '0, 3'd2, 64'd5, 64'd9, 1'b1, 64'd4, 1'b1);
    add_directed(FN_RECORD, '0, 3'd2, 64'd5, '0, 1'b0, '0, 1'b0);
    add_directed(FN_ACK_ONE, '0, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_ACK_ONE, REV_MAX, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_ACK_ONE, 64'd4, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_ACK_ONE, 64'd2, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_ACK_ONE, 64'd2, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_ACK_ONE, 64'd1, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_ACK_ONE, 64'd1, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_ACK_THRU, '0, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_ACK_THRU, REV_MAX, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_RECORD, '0, 3'd1, 64'd7, 64'd7, 1'b1, 64'd7, 1'b1);
    add_directed(FN_RECORD, '0, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_ACK_ONE, 64'd5, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_ACK_THRU, 64'd4, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_ACK_THRU, 64'd5, 3'd0, '0, '0, 1'b0, '0, 1'b0);
    add_directed(FN_NONE, REV_MAX, 3'd7, REV_MAX, REV_MAX, 1'b1, REV_MAX, 1'b1);
    run_phase(64'd5, 450, 50);
    run_phase(REV_MAX - 40, 250, 60);
    run_phase(REV_MAX, 60, 50);
    run_phase(rand64(), 500, 75);
    run_phase('0, 340, 50);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
